@@ rtl/gwwa_pkg.sv @@
// Shared types, codes and helpers of the greedy word-wrap aligner.
// No dependencies; gwwa_fifo, gwwa_front, gwwa_back and the top level refer to it by scoped names.
package gwwa_pkg;

  localparam int LINE_GLYPHS_DEF = 64;
  localparam int LINE_WORDS_DEF  = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam int MET_W           = 18;

  typedef enum logic [1:0] {
    KIND_GLYPH   = 2'd0,
    KIND_ALIGN   = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_EOT     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ALIGN_LEFT   = 2'd0,
    ALIGN_RIGHT  = 2'd1,
    ALIGN_CENTRE = 2'd2,
    ALIGN_BLOCK  = 2'd3
  } align_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_FONT_SIZE = 3'd2,
    REG_MAX_LINE  = 3'd3,
    REG_SPACE_ADV = 3'd4
  } reg_idx_t;

  typedef struct packed {
    kind_t                    kind;
    logic [15:0]              code;
    logic signed [MET_W-1:0]  kern;
    logic [MET_W-1:0]         adv;
    logic                     word_end;
    align_t                   align;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic [15:0]        font_size;
    logic [22:0]        max_len;
    logic [MET_W-1:0]   space_w;
    logic               y_load;
  } cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) r = 24'sh7FFFFF;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

@@ rtl/gwwa_if.sv @@
// Channel interfaces of the aligner: input items, result items, register writes.
// Plain valid/ready channels; no package dependency.
interface gwwa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        glyph_code;
  logic [13:0]        glyph_advance;
  logic signed [12:0] pair_kerning;
  logic               word_end;
  logic [1:0]         align_mode;
  modport source (output valid, kind, glyph_code, glyph_advance, pair_kerning, word_end,
                  align_mode, input ready);
  modport sink (input valid, kind, glyph_code, glyph_advance, pair_kerning, word_end,
                align_mode, output ready);
endinterface

interface gwwa_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_glyph;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic               line_last;
  logic               overflow_flag;
  modport source (output valid, out_glyph, pos_x, pos_y, line_last, overflow_flag,
                  input ready);
  modport sink (input valid, out_glyph, pos_x, pos_y, line_last, overflow_flag,
                output ready);
endinterface

interface gwwa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/greedy_word_wrap_aligner.sv @@
// Greedy word-wrap aligner, top level: front, command queue and back.
// Depends on gwwa_pkg, gwwa_if, gwwa_fifo, gwwa_front, gwwa_div and gwwa_back.
//
// Items enter a four-deep command queue, so input keeps flowing while a line is
// being emitted. The back handles one command at a time: a glyph is executed and, when
// it ends a word, the word is closed; an alignment item sets the mode. A line end runs
// setup and then a ring-buffer read, word step and output register per emitted glyph,
// after the serial divider when a block-aligned line has more than one word. Results
// leave through a registered output stage.
module greedy_word_wrap_aligner #(
  parameter int LINE_GLYPHS = gwwa_pkg::LINE_GLYPHS_DEF,
  parameter int LINE_WORDS  = gwwa_pkg::LINE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gwwa_in_if.sink     items,
  gwwa_cfg_if.sink    cfg,
  gwwa_out_if.source  results
);
  gwwa_pkg::cmd_t push_data;
  gwwa_pkg::cmd_t pop_data;
  gwwa_pkg::cfg_t cfg_regs;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  gwwa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .cfg_o     (cfg_regs)
  );

  gwwa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gwwa_back #(.LINE_GLYPHS(LINE_GLYPHS), .LINE_WORDS(LINE_WORDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .cmd       (pop_data),
    .cmd_valid (!empty),
    .pop       (pop),
    .results   (results)
  );
endmodule

@@ rtl/gwwa_fifo.sv @@
// Command queue between front and back of the aligner.
// Depends on gwwa_pkg for the command type and depth.
module gwwa_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gwwa_pkg::cmd_t       push_data,
  output logic                 full,
  input  logic                 pop,
  output gwwa_pkg::cmd_t       pop_data,
  output logic                 empty
);
  localparam int PW = $clog2(gwwa_pkg::FIFO_DEPTH);

  gwwa_pkg::cmd_t mem [gwwa_pkg::FIFO_DEPTH];
  logic [PW:0] wr_ptr;
  logic [PW:0] rd_ptr;

  assign empty    = (wr_ptr == rd_ptr);
  assign full     = (wr_ptr[PW-1:0] == rd_ptr[PW-1:0]) && (wr_ptr[PW] != rd_ptr[PW]);
  assign pop_data = mem[rd_ptr[PW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr[PW-1:0]] <= push_data;
  end
endmodule

@@ rtl/gwwa_front.sv @@
// Front of the aligner: register file, item intake, metric scaling.
// Depends on gwwa_pkg and gwwa_if; feeds gwwa_fifo.
module gwwa_front (
  input  logic            clk,
  input  logic            rst,
  gwwa_in_if.sink         items,
  gwwa_cfg_if.sink        cfg,
  output logic            push,
  output gwwa_pkg::cmd_t  push_data,
  input  logic            full,
  output gwwa_pkg::cfg_t  cfg_o
);
  localparam int MW = gwwa_pkg::MET_W;

  logic signed [23:0] origin_x;
  logic signed [23:0] origin_y;
  logic [15:0]        font_size;
  logic [22:0]        max_len;
  logic [13:0]        space_adv;
  logic [MW-1:0]      space_w;
  logic               y_load;

  logic [29:0]        adv_sum;
  logic [29:0]        space_sum;
  logic signed [30:0] kern_sum;

  assign items.ready = !full;
  assign push        = items.valid && !full;
  assign cfg.ready   = 1'b1;

  assign adv_sum   = 30'(font_size) * 30'(items.glyph_advance) + 30'd2048;
  assign space_sum = 30'(font_size) * 30'(space_adv) + 30'd2048;
  assign kern_sum  = 31'($signed({1'b0, font_size})) * 31'(items.pair_kerning) + 31'sd2048;

  always_comb begin
    push_data.kind     = gwwa_pkg::kind_t'(items.kind);
    push_data.code     = items.glyph_code;
    push_data.kern     = kern_sum[29:12];
    push_data.adv      = adv_sum[29:12];
    push_data.word_end = items.word_end;
    push_data.align    = gwwa_pkg::align_t'(items.align_mode);
  end

  assign cfg_o = '{origin_x: origin_x, origin_y: origin_y, font_size: font_size,
                   max_len: max_len, space_w: space_w, y_load: y_load};

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      font_size <= 16'd4096;
      max_len   <= 23'd163840;
      space_adv <= 14'd1024;
      space_w   <= MW'(1024);
      y_load    <= 1'b0;
    end else begin
      space_w <= space_sum[29:12];
      y_load  <= 1'b0;
      if (cfg.valid) begin
        case (gwwa_pkg::reg_idx_t'(cfg.index))
          gwwa_pkg::REG_ORIGIN_X: origin_x <= cfg.data;
          gwwa_pkg::REG_ORIGIN_Y: begin
            origin_y <= cfg.data;
            y_load   <= 1'b1;
          end
          gwwa_pkg::REG_FONT_SIZE: font_size <= cfg.data[15:0];
          gwwa_pkg::REG_MAX_LINE:  max_len   <= cfg.data[22:0];
          gwwa_pkg::REG_SPACE_ADV: space_adv <= cfg.data[13:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ rtl/gwwa_div.sv @@
// Serial restoring divider for the block-alignment gap, one quotient bit a cycle.
// Signed dividend, unsigned divisor, quotient truncated toward zero. No dependencies.
module gwwa_div #(
  parameter int NW = 25,
  parameter int DW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                done,
  output logic signed [NW:0]  quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [DW:0]   rem_sh;
  logic          take;

  assign rem_sh = {rem, quo[NW-1]};
  assign take   = (rem_sh >= {1'b0, dvs});
  assign quot   = neg ? -$signed((NW+1)'(quo)) : $signed((NW+1)'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        neg  <= dividend[NW-1];
        quo  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= take ? DW'(rem_sh - {1'b0, dvs}) : DW'(rem_sh);
        quo <= {quo[NW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/gwwa_back.sv @@
// Back of the aligner: word and line bookkeeping, glyph ring buffer, line emission.
// Depends on gwwa_pkg, gwwa_if and gwwa_div.
module gwwa_back #(
  parameter int LINE_GLYPHS = gwwa_pkg::LINE_GLYPHS_DEF,
  parameter int LINE_WORDS  = gwwa_pkg::LINE_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  gwwa_pkg::cfg_t  cfg,
  input  gwwa_pkg::cmd_t  cmd,
  input  logic            cmd_valid,
  output logic            pop,
  gwwa_out_if.source      results
);
  localparam int AW   = $clog2(LINE_GLYPHS);
  localparam int P    = 1 << AW;
  localparam int GCW  = $clog2(LINE_GLYPHS + 1);
  localparam int WAW  = $clog2(LINE_WORDS);
  localparam int WCW  = $clog2(LINE_WORDS + 1);
  localparam int XW   = 34;
  localparam int GAPW = 27;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_FW, S_POST, S_EL, S_DIV, S_EMRD, S_EMADV, S_EMOUT, S_ELFIN, S_EOT
  } state_t;

  state_t             state;
  gwwa_pkg::cmd_t     cmd_q;
  logic [GCW-1:0]     glyph_count;
  logic [GCW-1:0]     word_start;
  logic [WCW-1:0]     word_count;
  logic [AW-1:0]      base;
  logic signed [23:0] cww;
  logic signed [23:0] line;
  logic signed [23:0] y;
  gwwa_pkg::align_t   align;
  logic               sticky;
  logic               place_pend;
  logic signed [23:0] pend_w;
  logic [GCW-1:0]     ei;
  logic [WAW-1:0]     wi;
  logic signed [XW-1:0]   x_run;
  logic signed [GAPW-1:0] gap;

  logic [15:0]        g_code [P];
  logic signed [23:0] g_off [P];
  logic               g_first [P];
  logic signed [23:0] ww [LINE_WORDS];
  logic [15:0]        code_q;
  logic signed [23:0] off_q;
  logic               first_q;
  logic signed [23:0] ww_q;

  logic               g_we;
  logic [AW-1:0]      g_waddr;
  logic               ww_we;
  logic [WAW-1:0]     ww_waddr;
  logic signed [23:0] ww_wdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  logic signed [23:0] k_sum;
  logic signed [23:0] w1;
  logic signed [23:0] w2;
  logic signed [26:0] fit_sum;
  logic signed [26:0] max_ext;
  logic               fits;
  logic               word_ok;
  logic signed [23:0] line_add;
  logic signed [24:0] slack;
  logic signed [24:0] slack_adj;
  logic signed [24:0] half;
  logic signed [24:0] x0;
  logic signed [XW-1:0] x_adv;
  logic signed [23:0] x_out;
  logic signed [23:0] y_step;
  logic               div_start;
  logic               div_done;
  logic signed [25:0] quot;

  assign k_sum    = gwwa_pkg::sat24(40'(cww) + 40'(cmd_q.kern));
  assign w1       = (cww != 24'sd0) ? k_sum : cww;
  assign w2       = gwwa_pkg::sat24(40'(w1) + 40'(cmd_q.adv));
  assign fit_sum  = 27'(line) + 27'(cfg.space_w) + 27'(cww);
  assign max_ext  = 27'(cfg.max_len);
  assign fits     = fit_sum < max_ext;
  assign word_ok  = (word_count == '0) || (fits && (word_count < WCW'(LINE_WORDS)));
  assign line_add = gwwa_pkg::sat24(40'(line) + 40'(cww) + 40'(cfg.space_w));
  assign slack    = 25'(cfg.max_len) - 25'(line);
  assign slack_adj = slack + 25'(slack[24]);
  assign half     = slack_adj >>> 1;
  assign x_adv    = x_run + XW'(ww_q) + XW'(gap);
  assign x_out    = gwwa_pkg::sat24(40'(x_run) + 40'(off_q));
  assign y_step   = gwwa_pkg::sat24(40'(y) - 40'(cfg.font_size));

  always_comb begin
    case (align)
      gwwa_pkg::ALIGN_RIGHT:  x0 = slack;
      gwwa_pkg::ALIGN_CENTRE: x0 = half;
      default:                x0 = 25'(cfg.origin_x);
    endcase
  end

  assign pop       = (state == S_IDLE) && cmd_valid;
  assign div_start = (state == S_EL) && (word_count > WCW'(1))
                     && (align == gwwa_pkg::ALIGN_BLOCK);

  assign g_we     = (state == S_EXEC) && (cmd_q.kind == gwwa_pkg::KIND_GLYPH)
                    && (glyph_count < GCW'(LINE_GLYPHS));
  assign g_waddr  = base + glyph_count[AW-1:0];
  assign ww_we    = ((state == S_FW) && (glyph_count > word_start) && word_ok)
                    || ((state == S_ELFIN) && place_pend);
  assign ww_waddr = (state == S_ELFIN) ? '0 : word_count[WAW-1:0];
  assign ww_wdata = (state == S_ELFIN) ? pend_w : cww;
  assign rd_en    = (state == S_EMRD);
  assign rd_addr  = base + ei[AW-1:0];

  gwwa_div #(.NW(25), .DW(WCW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (slack),
    .divisor  (word_count - WCW'(1)),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (g_we) begin
      g_code[g_waddr]  <= cmd_q.code;
      g_off[g_waddr]   <= w1;
      g_first[g_waddr] <= (glyph_count == word_start);
    end
    if (ww_we) ww[ww_waddr] <= ww_wdata;
    if (rd_en) begin
      code_q  <= g_code[rd_addr];
      off_q   <= g_off[rd_addr];
      first_q <= g_first[rd_addr];
      ww_q    <= ww[wi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      glyph_count   <= '0;
      word_start    <= '0;
      word_count    <= '0;
      base          <= '0;
      cww           <= '0;
      line          <= '0;
      y             <= '0;
      align         <= gwwa_pkg::ALIGN_LEFT;
      sticky        <= 1'b0;
      place_pend    <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) results.valid <= 1'b0;
      if (cfg.y_load) y <= cfg.origin_y;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.kind)
            gwwa_pkg::KIND_GLYPH: begin
              if (glyph_count >= GCW'(LINE_GLYPHS)) begin
                sticky <= 1'b1;
              end else begin
                glyph_count <= glyph_count + 1'b1;
                cww         <= w2;
              end
              state <= cmd_q.word_end ? S_FW : S_IDLE;
            end
            gwwa_pkg::KIND_ALIGN: begin
              align <= cmd_q.align;
              state <= S_IDLE;
            end
            default: state <= S_FW;
          endcase
        end
        S_FW: begin
          cww   <= '0;
          state <= S_POST;
          if (glyph_count > word_start) begin
            if (word_count == '0) begin
              line       <= cww;
              word_count <= WCW'(1);
              word_start <= glyph_count;
            end else if (fits) begin
              if (word_count >= WCW'(LINE_WORDS)) begin
                glyph_count <= word_start;
                sticky      <= 1'b1;
              end else begin
                line       <= line_add;
                word_count <= word_count + 1'b1;
                word_start <= glyph_count;
              end
            end else begin
              pend_w     <= cww;
              place_pend <= 1'b1;
              state      <= S_EL;
            end
          end
        end
        S_POST: begin
          case (cmd_q.kind)
            gwwa_pkg::KIND_NEWLINE: state <= S_EL;
            gwwa_pkg::KIND_EOT:     state <= (word_count != '0) ? S_EL : S_EOT;
            default:                state <= S_IDLE;
          endcase
        end
        S_EL: begin
          ei    <= '0;
          wi    <= '0;
          x_run <= XW'(x0);
          gap   <= GAPW'(cfg.space_w);
          if (word_count == '0) state <= S_ELFIN;
          else if (div_start) state <= S_DIV;
          else state <= S_EMRD;
        end
        S_DIV: begin
          if (div_done) begin
            gap   <= GAPW'(cfg.space_w) + GAPW'(quot);
            state <= S_EMRD;
          end
        end
        S_EMRD: state <= S_EMADV;
        S_EMADV: begin
          if ((ei != '0) && first_q) begin
            x_run <= x_adv;
            wi    <= wi + 1'b1;
          end
          state <= S_EMOUT;
        end
        S_EMOUT: begin
          if (!results.valid || results.ready) begin
            results.valid         <= 1'b1;
            results.out_glyph     <= code_q;
            results.pos_x         <= x_out;
            results.pos_y         <= y;
            results.line_last     <= (ei == word_start - GCW'(1));
            results.overflow_flag <= sticky;
            if (ei == word_start - GCW'(1)) begin
              state <= S_ELFIN;
            end else begin
              ei    <= ei + 1'b1;
              state <= S_EMRD;
            end
          end
        end
        S_ELFIN: begin
          y <= y_step;
          if (word_count != '0) begin
            base        <= base + word_start[AW-1:0];
            glyph_count <= glyph_count - word_start;
            word_start  <= '0;
            word_count  <= '0;
            line        <= '0;
          end
          if (place_pend) begin
            place_pend <= 1'b0;
            line       <= pend_w;
            word_count <= WCW'(1);
            word_start <= glyph_count - word_start;
            state      <= S_POST;
          end else begin
            state <= (cmd_q.kind == gwwa_pkg::KIND_EOT) ? S_EOT : S_IDLE;
          end
        end
        S_EOT: begin
          glyph_count <= '0;
          word_start  <= '0;
          y           <= cfg.origin_y;
          align       <= gwwa_pkg::ALIGN_LEFT;
          sticky      <= 1'b0;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/greedy_word_wrap_aligner_tb.sv @@
// Self-checking testbench of greedy_word_wrap_aligner: directed and random item streams.
// Depends on gwwa_pkg and the channel interfaces in gwwa_if; predicts every placed glyph
// and checks each result item in order.
module greedy_word_wrap_aligner_tb;
  import gwwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGLYPH = 64;
  localparam int NWORD = 32;
  localparam longint SMAX = 8388607;
  localparam longint SMIN = -8388608;
  localparam int SETTLE_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    kind_t              kind;
    logic [15:0]        code;
    logic [13:0]        adv;
    logic signed [12:0] kern;
    logic               we;
    align_t             al;
  } text_item_t;

  typedef struct {
    logic [15:0] glyph;
    logic [23:0] x;
    logic [23:0] y;
    logic        last;
    logic        ovf;
  } placed_glyph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gwwa_in_if  items ();
  gwwa_cfg_if cfg ();
  gwwa_out_if results ();

  greedy_word_wrap_aligner uut (
    .clk(clk), .rst(rst), .items(items.sink), .cfg(cfg.sink), .results(results.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  longint p_ox, p_oy, p_font, p_max, p_space;
  logic [15:0] p_code [NGLYPH];
  longint p_off [NGLYPH];
  int p_gword [NGLYPH];
  longint p_wwidth [NWORD];
  int p_glyphs, p_words, p_wstart, p_nres;
  longint p_word_w, p_line_w, p_y;
  align_t p_align;
  logic p_drop;

  placed_glyph_t placed_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_lines = 0;
  bit quiet = 0;
  int hold_len = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic longint sat(longint v);
    return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
  endfunction

  function automatic longint scaled(longint m);
    longint q;
    q = p_font * m + 2048;
    if (q >= 0) return q / 4096;
    return -((-q + 4095) / 4096);
  endfunction

  function automatic void place(int i, longint x, bit last);
    placed_glyph_t g;
    if (p_nres >= 64) return;
    g.glyph = p_code[i];
    g.x = sat(x);
    g.y = p_y;
    g.last = last;
    g.ovf = p_drop;
    placed_q.push_back(g);
    p_nres++;
  endfunction

  function automatic void flush_line();
    int tag, rest;
    longint x, gap, slack;
    if (p_words > 0) begin
      gap = scaled(p_space);
      slack = p_max - p_line_w;
      x = p_ox;
      tag = 0;
      if (p_align == ALIGN_RIGHT) x = slack;
      else if (p_align == ALIGN_CENTRE) x = slack / 2;
      else if (p_align == ALIGN_BLOCK && p_words > 1) gap += slack / (p_words - 1);
      for (int i = 0; i < p_wstart; i++) begin
        while (tag < p_gword[i] && tag < p_words) begin
          x += p_wwidth[tag] + gap;
          tag++;
        end
        place(i, x + p_off[i], i == p_wstart - 1);
      end
      n_lines++;
      rest = p_glyphs - p_wstart;
      for (int i = 0; i < rest; i++) begin
        p_code[i] = p_code[p_wstart + i];
        p_off[i] = p_off[p_wstart + i];
        p_gword[i] = 0;
      end
      p_glyphs = rest;
      p_wstart = 0;
      p_words = 0;
      p_line_w = 0;
    end
    p_y = sat(p_y - p_font);
  endfunction

  function automatic void take_word(longint w);
    p_wwidth[p_words] = w;
    p_words++;
    p_wstart = p_glyphs;
  endfunction

  function automatic void close_word();
    longint w, space;
    w = p_word_w;
    space = scaled(p_space);
    p_word_w = 0;
    if (p_glyphs <= p_wstart) return;
    if (p_words == 0) begin
      p_line_w = w;
      take_word(w);
    end else if (p_line_w + space + w < p_max) begin
      if (p_words >= NWORD) begin
        p_glyphs = p_wstart;
        p_drop = 1'b1;
      end else begin
        p_line_w = sat(p_line_w + w + space);
        take_word(w);
      end
    end else begin
      flush_line();
      p_line_w = w;
      take_word(w);
    end
  endfunction

  function automatic void predict_item(text_item_t it);
    p_nres = 0;
    case (it.kind)
      KIND_GLYPH: begin
        if (p_glyphs >= NGLYPH) begin
          p_drop = 1'b1;
        end else begin
          if (p_word_w != 0) p_word_w = sat(p_word_w + scaled(longint'(it.kern)));
          p_code[p_glyphs] = it.code;
          p_off[p_glyphs] = p_word_w;
          p_gword[p_glyphs] = p_words;
          p_glyphs++;
          p_word_w = sat(p_word_w + scaled(longint'({1'b0, it.adv})));
        end
        if (it.we) close_word();
      end
      KIND_ALIGN: p_align = it.al;
      KIND_NEWLINE: begin
        close_word();
        flush_line();
      end
      default: begin
        close_word();
        if (p_words > 0) flush_line();
        p_glyphs = 0;
        p_wstart = 0;
        p_y = p_oy;
        p_align = ALIGN_LEFT;
        p_drop = 1'b0;
      end
    endcase
  endfunction

  function automatic void predict_reg(reg_idx_t idx, logic [23:0] v);
    case (idx)
      REG_ORIGIN_X: p_ox = longint'($signed(v));
      REG_ORIGIN_Y: begin
        p_oy = longint'($signed(v));
        p_y = p_oy;
      end
      REG_FONT_SIZE: p_font = v[15:0];
      REG_MAX_LINE: p_max = v[22:0];
      REG_SPACE_ADV: p_space = v[13:0];
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    placed_glyph_t e;
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1) begin
      n_results++;
      if (placed_q.size() == 0) begin
        $display("%0t: unexpected result glyph=%h x=%h y=%h", $time, results.out_glyph,
                 results.pos_x, results.pos_y);
        errors++;
      end else begin
        e = placed_q.pop_front();
        if (results.out_glyph !== e.glyph) begin
          $display("%0t: out_glyph expected %h actual %h", $time, e.glyph, results.out_glyph);
          errors++;
        end
        if (results.pos_x !== e.x) begin
          $display("%0t: pos_x expected %h actual %h", $time, e.x, results.pos_x);
          errors++;
        end
        if (results.pos_y !== e.y) begin
          $display("%0t: pos_y expected %h actual %h", $time, e.y, results.pos_y);
          errors++;
        end
        if (results.line_last !== e.last) begin
          $display("%0t: line_last expected %b actual %b", $time, e.last, results.line_last);
          errors++;
        end
        if (results.overflow_flag !== e.ovf) begin
          $display("%0t: overflow_flag expected %b actual %b", $time, e.ovf,
                   results.overflow_flag);
          errors++;
        end
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  always @(posedge clk) begin
    if (hold_len > 0) begin
      results.ready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (quiet) begin
      results.ready <= 1'b1;
    end else if (stall_left > 0) begin
      results.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      results.ready <= 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((items.valid === 1'b1 && items.ready === 1'b1) ||
        (cfg.valid === 1'b1 && cfg.ready === 1'b1) ||
        (results.valid === 1'b1 && results.ready === 1'b1) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input text_item_t it);
    items.valid <= 1'b1;
    items.kind <= it.kind;
    items.glyph_code <= it.code;
    items.glyph_advance <= it.adv;
    items.pair_kerning <= it.kern;
    items.word_end <= it.we;
    items.align_mode <= it.al;
    do @(posedge clk); while (!(items.valid === 1'b1 && items.ready === 1'b1));
    predict_item(it);
    n_items++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic glyph(input logic [15:0] code, input logic [13:0] adv,
                       input logic signed [12:0] kern, input logic we);
    text_item_t it;
    it = '{KIND_GLYPH, code, adv, kern, we, ALIGN_LEFT};
    send_item(it);
  endtask

  task automatic control(input kind_t k, input align_t al);
    text_item_t it;
    it = '{k, 16'($urandom), 14'($urandom), 13'($urandom), 1'($urandom), al};
    send_item(it);
  endtask

  task automatic settle();
    items.valid <= 1'b0;
    @(posedge clk);
    while (placed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [23:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    do @(posedge clk); while (!(cfg.valid === 1'b1 && cfg.ready === 1'b1));
    predict_reg(idx, v);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [23:0] ox, input logic [23:0] oy, input logic [15:0] fs,
                       input logic [22:0] ml, input logic [13:0] sp);
    settle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_FONT_SIZE, fs);
    write_reg(REG_MAX_LINE, ml);
    write_reg(REG_SPACE_ADV, sp);
  endtask

  task automatic random_word();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      glyph(16'($urandom), $urandom_range(0, 7) == 0 ? 14'($urandom) : 14'($urandom_range(0, 4095)),
            13'($urandom), (i == len - 1) ? ($urandom_range(0, 15) != 0) : 1'b0);
  endtask

  task automatic random_text(input int n);
    int start, pick;
    start = n_items;
    while (n_items - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) random_word();
      else if (pick < 86) control(KIND_ALIGN, align_t'($urandom_range(0, 3)));
      else if (pick < 92) control(KIND_NEWLINE, ALIGN_LEFT);
      else if (pick < 96) control(KIND_EOT, ALIGN_LEFT);
      else glyph(16'($urandom), 14'($urandom), 13'($urandom), 1'($urandom));
    end
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_left_extremes();
    glyph(16'h0000, 14'h0000, 13'sh0FFF, 1'b0);
    glyph(16'hFFFF, 14'h3FFF, -13'sd4096, 1'b1);
    glyph(16'h1234, 14'd2048, 13'sd0, 1'b1);
    glyph(16'h5A5A, 14'd1000, 13'sd300, 1'b0);
    glyph(16'hA5A5, 14'd1500, -13'sd200, 1'b1);
    control(KIND_NEWLINE, ALIGN_LEFT);
    glyph(16'h0042, 14'd3000, 13'sd0, 1'b1);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_alignments();
    for (int a = 0; a < 4; a++) begin
      control(KIND_ALIGN, align_t'(a));
      for (int w = 0; w < 3; w++) glyph(16'(a * 16 + w), 14'd4000, 13'sd50, 1'b1);
      control(KIND_NEWLINE, ALIGN_LEFT);
    end
    control(KIND_ALIGN, ALIGN_BLOCK);
    glyph(16'h0B01, 14'd2000, 13'sd0, 1'b1);
    glyph(16'h0B02, 14'd2000, 13'sd0, 1'b1);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_empty_and_unterminated();
    control(KIND_NEWLINE, ALIGN_LEFT);
    control(KIND_NEWLINE, ALIGN_LEFT);
    glyph(16'h0C01, 14'd1200, 13'sd0, 1'b0);
    control(KIND_NEWLINE, ALIGN_LEFT);
    glyph(16'h0C02, 14'd900, 13'sd0, 1'b0);
    control(KIND_EOT, ALIGN_LEFT);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_wrap_greedy();
    // single-glyph words of advance 8000 wrap after every third word, four lines in all
    for (int i = 0; i < 12; i++) glyph(16'(i), 14'd8000, 13'($urandom), 1'b1);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_glyph_overflow();
    for (int i = 0; i < NGLYPH + 3; i++) glyph(16'(i), 14'd10, 13'sd5, 1'b0);
    glyph(16'hEEEE, 14'd10, 13'sd5, 1'b1);
    control(KIND_NEWLINE, ALIGN_LEFT);
    glyph(16'h0D01, 14'd10, 13'sd0, 1'b1);
    control(KIND_EOT, ALIGN_LEFT);
    glyph(16'h0D02, 14'd10, 13'sd0, 1'b1);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_word_overflow();
    for (int i = 0; i < NWORD + 3; i++) glyph(16'(i + 256), 14'd20, 13'sd0, 1'b1);
    control(KIND_ALIGN, ALIGN_BLOCK);
    control(KIND_NEWLINE, ALIGN_LEFT);
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_backpressure();
    hold_len = 400;
    for (int i = 0; i < 40; i++) glyph(16'($urandom), 14'd3000, 13'($urandom), 1'($urandom));
    control(KIND_EOT, ALIGN_LEFT);
  endtask

  task automatic test_config_sweep();
    setup(24'h800000, 24'h7FFFFF, 16'hFFFF, 23'h7FFFFF, 14'h3FFF);
    random_text(15);
    setup(24'h7FFFFF, 24'h800000, 16'h0000, 23'h000000, 14'h0000);
    random_text(10);
    setup(24'h7FFF00, 24'h000100, 16'h2000, 23'h000000, 14'h3FFF);
    random_text(10);
    setup(24'(-25600), 24'h7FFFFF, 16'h4000, 23'h7FFFFF, 14'h0000);
    random_text(10);
  endtask

  initial begin
    items.valid = 1'b0;
    items.kind = KIND_GLYPH;
    items.glyph_code = '0;
    items.glyph_advance = '0;
    items.pair_kerning = '0;
    items.word_end = 1'b0;
    items.align_mode = ALIGN_LEFT;
    cfg.valid = 1'b0;
    cfg.index = REG_ORIGIN_X;
    cfg.data = '0;
    results.ready = 1'b0;
    p_ox = 0; p_oy = 0; p_font = 4096; p_max = 163840; p_space = 1024;
    p_glyphs = 0; p_words = 0; p_wstart = 0; p_word_w = 0; p_line_w = 0;
    p_y = 0; p_align = ALIGN_LEFT; p_drop = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_left_extremes();
    test_alignments();
    test_empty_and_unterminated();
    setup(24'h000400, 24'h001000, 16'h1000, 23'd32768, 14'd1024);
    test_wrap_greedy();
    test_glyph_overflow();
    setup(24'h000000, 24'h000000, 16'h1000, 23'h7FFFFF, 14'd100);
    test_word_overflow();
    setup(24'h000000, 24'hFFF000, 16'h1000, 23'd40000, 14'd1024);
    test_backpressure();
    test_config_sweep();
    setup(24'h000800, 24'h010000, 16'h1000, 23'd163840, 14'd1024);
    random_text(60);
    quiet = 1;
    random_text(25);

    settle();
    $display("covered %0d items, %0d placed glyphs, %0d emitted lines", n_items, n_results,
             n_lines);
    $display("alignments, wrapping, buffer overflows, register extremes and stalls exercised");
    if (errors == 0 && placed_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
